// ----- rtl/psc_pkg.sv -----
// shared types, register indexes and constants of the pressure sensor compensation block
package psc_pkg;

	// register indexes on the configuration port (byte address is four times the index)
	localparam logic [2:0] REG_C1   = 3'd0;
	localparam logic [2:0] REG_C2   = 3'd1;
	localparam logic [2:0] REG_C3   = 3'd2;
	localparam logic [2:0] REG_C4   = 3'd3;
	localparam logic [2:0] REG_C5   = 3'd4;
	localparam logic [2:0] REG_C6   = 3'd5;
	localparam logic [2:0] REG_SALT = 3'd6;

	// output limits
	localparam logic signed [19:0] TEMP_LO  = -20'sd10000;
	localparam logic signed [19:0] TEMP_HI  = 20'sd20000;
	localparam logic signed [28:0] PRES_HI  = 29'sd300000;
	localparam logic signed [20:0] DEPTH_LO = -21'sd11000;
	localparam logic signed [20:0] DEPTH_HI = 21'sd300000;

	// depth scale factors and surface pressure offset (2 x 1013.25 mbar in 0.1 mbar)
	localparam logic [16:0] K_FRESH = 17'd66828;
	localparam logic [16:0] K_SALT  = 17'd65176;
	localparam logic signed [20:0] SURFACE_2P = 21'sd20265;

	// calibration words as held in the register bank
	typedef struct packed {
		logic [15:0] c1;
		logic [15:0] c2;
		logic [15:0] c3;
		logic [15:0] c4;
		logic [15:0] c5;
		logic [15:0] c6;
		logic        salt;
	} cal_t;

	// hand-over from the compensation stages to the pressure stages
	typedef struct packed {
		logic [23:0]        d1;
		logic signed [39:0] off2;
		logic signed [39:0] sens2;
		logic signed [15:0] temp;
	} comp_t;

endpackage

// ----- rtl/pressure_sensor_compensation.sv -----
// top level: calibration register bank and the twelve-stage compensation pipeline
// throughput: one transaction per cycle while result_stall is low; each stage holds while full and blocked, so bubbles
// are squeezed out and a waiting result does not stop new samples entering empty stages
// the widest step is the split 24 x 40 bit pressure product, a 24 x 20 and a 25 x 20 partial
// reset: clears all valid bits and sets every calibration register and the water select to zero
module pressure_sensor_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [23:0]        raw_pressure,
	input  logic [23:0]        raw_temperature,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [15:0] temperature_centi_c,
	output logic [18:0]        pressure_tenth_mbar,
	output logic signed [19:0] depth_mm
);

	psc_pkg::cal_t  cal_q;
	logic [2:0]     reg_idx;
	logic           wr_en;
	logic           comp_valid, comp_ready, sample_ready;
	psc_pkg::comp_t comp_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				psc_pkg::REG_C1:   cal_q.c1   <= pwdata[15:0];
				psc_pkg::REG_C2:   cal_q.c2   <= pwdata[15:0];
				psc_pkg::REG_C3:   cal_q.c3   <= pwdata[15:0];
				psc_pkg::REG_C4:   cal_q.c4   <= pwdata[15:0];
				psc_pkg::REG_C5:   cal_q.c5   <= pwdata[15:0];
				psc_pkg::REG_C6:   cal_q.c6   <= pwdata[15:0];
				psc_pkg::REG_SALT: cal_q.salt <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			psc_pkg::REG_C1:   prdata = {16'd0, cal_q.c1};
			psc_pkg::REG_C2:   prdata = {16'd0, cal_q.c2};
			psc_pkg::REG_C3:   prdata = {16'd0, cal_q.c3};
			psc_pkg::REG_C4:   prdata = {16'd0, cal_q.c4};
			psc_pkg::REG_C5:   prdata = {16'd0, cal_q.c5};
			psc_pkg::REG_C6:   prdata = {16'd0, cal_q.c6};
			psc_pkg::REG_SALT: prdata = {31'd0, cal_q.salt};
			default:           prdata = 32'd0;
		endcase
	end

	assign sample_stall = !sample_ready;

	// compensation stages
	psc_comp u_comp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal_q),
		.up_valid        (sample_valid),
		.up_ready        (sample_ready),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.dn_valid        (comp_valid),
		.dn_ready        (comp_ready),
		.dn_data         (comp_data)
	);

	// pressure and depth stages
	psc_pres u_pres (
		.clk                 (clk),
		.arst_n              (arst_n),
		.salt                (cal_q.salt),
		.up_valid            (comp_valid),
		.up_ready            (comp_ready),
		.up_data             (comp_data),
		.res_valid           (result_valid),
		.res_stall           (result_stall),
		.temperature_centi_c (temperature_centi_c),
		.pressure_tenth_mbar (pressure_tenth_mbar),
		.depth_mm            (depth_mm)
	);

endmodule

// ----- rtl/psc_comp.sv -----
// stages one to five: dT, TEMP, OFF, SENS and the second-order corrections
module psc_comp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psc_pkg::cal_t        cal,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  logic [23:0]          raw_pressure,
	input  logic [23:0]          raw_temperature,
	output logic                 dn_valid,
	input  logic                 dn_ready,
	output psc_pkg::comp_t       dn_data
);

	localparam logic signed [18:0] TEMP_REF   = 19'sd2000;
	localparam logic signed [18:0] TEMP_VCOLD = -19'sd1500;
	localparam logic signed [18:0] VCOLD_OFS  = 19'sd1500;

	// stage enables: a stage moves when empty or when the next one moves
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign adv_s5   = !vld_s5 || dn_ready;
	assign adv_s4   = !vld_s4 || adv_s5;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign up_ready = adv_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= up_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: dT = D2 - C5 * 256
	logic [23:0]        d1_s1;
	logic signed [24:0] dt_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.c5, 8'd0});
		end
	end

	// stage 2: products of dT
	logic [23:0]        d1_s2;
	logic signed [41:0] dtc6_s2, c4dt_s2, c3dt_s2;
	logic [47:0]        dtsq_s2;
	logic signed [49:0] dtsq_full;

	assign dtsq_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			d1_s2   <= d1_s1;
			dtc6_s2 <= dt_s1 * $signed({1'b0, cal.c6});
			c4dt_s2 <= dt_s1 * $signed({1'b0, cal.c4});
			c3dt_s2 <= dt_s1 * $signed({1'b0, cal.c3});
			dtsq_s2 <= dtsq_full[47:0];
		end
	end

	// stage 3: truncating scale-downs give TEMP, OFF, SENS and both Ti candidates
	logic signed [41:0] dtc6_b, c4dt_b, c3dt_b, dev_w, c4q, c3q, off_w, sens_w;
	logic signed [17:0] dev_n;
	logic [49:0]        dtsq3;
	logic [50:0]        dtsq7;
	logic [23:0]        d1_s3;
	logic signed [17:0] dev_s3;
	logic signed [18:0] temp_s3;
	logic signed [39:0] off_s3, sens_s3;
	logic [16:0]        ti_cold_s3;
	logic [13:0]        ti_warm_s3;

	assign dtc6_b = dtc6_s2 + (dtc6_s2[41] ? 42'sd8388607 : 42'sd0);
	assign c4dt_b = c4dt_s2 + (c4dt_s2[41] ? 42'sd127 : 42'sd0);
	assign c3dt_b = c3dt_s2 + (c3dt_s2[41] ? 42'sd255 : 42'sd0);
	assign dev_w  = dtc6_b >>> 23;
	assign dev_n  = dev_w[17:0];
	assign c4q    = c4dt_b >>> 7;
	assign c3q    = c3dt_b >>> 8;
	assign off_w  = $signed({10'd0, cal.c2, 16'd0}) + c4q;
	assign sens_w = $signed({11'd0, cal.c1, 15'd0}) + c3q;
	assign dtsq3  = {2'd0, dtsq_s2} + {1'b0, dtsq_s2, 1'b0};
	assign dtsq7  = {dtsq_s2, 3'd0} - {3'd0, dtsq_s2};

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			d1_s3      <= d1_s2;
			dev_s3     <= dev_n;
			temp_s3    <= $signed({dev_n[17], dev_n}) + TEMP_REF;
			off_s3     <= off_w[39:0];
			sens_s3    <= sens_w[39:0];
			ti_cold_s3 <= dtsq3[49:33];
			ti_warm_s3 <= dtsq7[50:37];
		end
	end

	// stage 4: squares for the corrections, corrected temperature
	logic               cold, vcold;
	logic [16:0]        ti_sel;
	logic signed [18:0] lo_n;
	logic signed [35:0] devsq_full;
	logic signed [37:0] losq_full;
	logic [23:0]        d1_s4;
	logic signed [19:0] temp2_s4;
	logic               cold_s4, vcold_s4;
	logic [33:0]        devsq_s4;
	logic [34:0]        losq_s4;
	logic signed [39:0] off_s4, sens_s4;

	assign cold       = temp_s3 < TEMP_REF;
	assign vcold      = temp_s3 < TEMP_VCOLD;
	assign ti_sel     = cold ? ti_cold_s3 : {3'd0, ti_warm_s3};
	assign lo_n       = temp_s3 + VCOLD_OFS;
	assign devsq_full = dev_s3 * dev_s3;
	assign losq_full  = lo_n * lo_n;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			d1_s4    <= d1_s3;
			temp2_s4 <= $signed({temp_s3[18], temp_s3}) - $signed({3'd0, ti_sel});
			cold_s4  <= cold;
			vcold_s4 <= vcold;
			devsq_s4 <= devsq_full[33:0];
			losq_s4  <= losq_full[34:0];
			off_s4   <= off_s3;
			sens_s4  <= sens_s3;
		end
	end

	// stage 5: OFF2, SENS2 and the saturated temperature
	logic [35:0]        dv3;
	logic [36:0]        dv5;
	logic [37:0]        lq7;
	logic [36:0]        lq4;
	logic [38:0]        offi;
	logic [37:0]        sensi;
	logic signed [15:0] t_sat;
	psc_pkg::comp_t     comp_s5;

	assign dv3 = {2'd0, devsq_s4} + {1'b0, devsq_s4, 1'b0};
	assign dv5 = {3'd0, devsq_s4} + {1'b0, devsq_s4, 2'd0};
	assign lq7 = {losq_s4, 3'd0} - {3'd0, losq_s4};
	assign lq4 = {losq_s4, 2'd0};

	always_comb begin
		if (cold_s4) begin
			offi  = {4'd0, dv3[35:1]} + (vcold_s4 ? {1'b0, lq7} : 39'd0);
			sensi = {4'd0, dv5[36:3]} + (vcold_s4 ? {1'b0, lq4} : 38'd0);
		end else begin
			offi  = {9'd0, devsq_s4[33:4]};
			sensi = 38'd0;
		end
	end

	// temperature saturation
	always_comb begin
		priority if (temp2_s4 < psc_pkg::TEMP_LO) begin
			t_sat = psc_pkg::TEMP_LO[15:0];
		end else if (temp2_s4 > psc_pkg::TEMP_HI) begin
			t_sat = psc_pkg::TEMP_HI[15:0];
		end else begin
			t_sat = temp2_s4[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			comp_s5.d1    <= d1_s4;
			comp_s5.off2  <= off_s4 - $signed({1'b0, offi});
			comp_s5.sens2 <= sens_s4 - $signed({2'd0, sensi});
			comp_s5.temp  <= t_sat;
		end
	end

	assign dn_valid = vld_s5;
	assign dn_data  = comp_s5;

endmodule

// ----- rtl/psc_pres.sv -----
// stages six to twelve: pressure from D1, SENS2 and OFF2, then depth and the output register
module psc_pres (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 salt,
	input  logic                 up_valid,
	output logic                 up_ready,
	input  psc_pkg::comp_t       up_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic signed [15:0]   temperature_centi_c,
	output logic [18:0]          pressure_tenth_mbar,
	output logic signed [19:0]   depth_mm
);

	// stage enables
	logic adv_s6, adv_s7, adv_s8, adv_s9, adv_s10, adv_s11, adv_s12;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;

	assign adv_s12  = !vld_s12 || !res_stall;
	assign adv_s11  = !vld_s11 || adv_s12;
	assign adv_s10  = !vld_s10 || adv_s11;
	assign adv_s9   = !vld_s9 || adv_s10;
	assign adv_s8   = !vld_s8 || adv_s9;
	assign adv_s7   = !vld_s7 || adv_s8;
	assign adv_s6   = !vld_s6 || adv_s7;
	assign up_ready = adv_s6;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			if (adv_s6)  vld_s6  <= up_valid;
			if (adv_s7)  vld_s7  <= vld_s6;
			if (adv_s8)  vld_s8  <= vld_s7;
			if (adv_s9)  vld_s9  <= vld_s8;
			if (adv_s10) vld_s10 <= vld_s9;
			if (adv_s11) vld_s11 <= vld_s10;
			if (adv_s12) vld_s12 <= vld_s11;
		end
	end

	// stage 6: D1 * SENS2 as two partial products on a 20-bit split
	logic [43:0]        pp_lo_s6;
	logic signed [44:0] pp_hi_s6;
	logic signed [39:0] off2_s6;
	logic signed [15:0] temp_s6;

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			pp_lo_s6 <= up_data.d1 * up_data.sens2[19:0];
			pp_hi_s6 <= $signed({1'b0, up_data.d1}) * $signed(up_data.sens2[39:20]);
			off2_s6  <= up_data.off2;
			temp_s6  <= up_data.temp;
		end
	end

	// stage 7: recombine the partial products
	logic signed [63:0] full_s7;
	logic signed [39:0] off2_s7;
	logic signed [15:0] temp_s7;

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			full_s7 <= $signed({pp_hi_s6[43:0], 20'd0}) + $signed({20'd0, pp_lo_s6});
			off2_s7 <= off2_s6;
			temp_s7 <= temp_s6;
		end
	end

	// stage 8: divide by 2^21 toward zero
	logic signed [63:0] full_b, full_q;
	logic signed [42:0] q1_s8;
	logic signed [39:0] off2_s8;
	logic signed [15:0] temp_s8;

	assign full_b = full_s7 + (full_s7[63] ? 64'sd2097151 : 64'sd0);
	assign full_q = full_b >>> 21;

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			q1_s8   <= full_q[42:0];
			off2_s8 <= off2_s7;
			temp_s8 <= temp_s7;
		end
	end

	// stage 9: subtract OFF2
	logic signed [43:0] x_s9;
	logic signed [15:0] temp_s9;

	always_ff @(posedge clk) begin
		if (adv_s9) begin
			x_s9    <= $signed({q1_s8[42], q1_s8}) - $signed({{4{off2_s8[39]}}, off2_s8});
			temp_s9 <= temp_s8;
		end
	end

	// stage 10: divide by 2^15 toward zero and saturate
	logic signed [43:0] x_b, x_q;
	logic signed [28:0] p_n;
	logic [18:0]        p_sat;
	logic [18:0]        pres_s10;
	logic signed [15:0] temp_s10;

	assign x_b = x_s9 + (x_s9[43] ? 44'sd32767 : 44'sd0);
	assign x_q = x_b >>> 15;
	assign p_n = x_q[28:0];

	always_comb begin
		priority if (p_n[28]) begin
			p_sat = 19'd0;
		end else if (p_n > psc_pkg::PRES_HI) begin
			p_sat = psc_pkg::PRES_HI[18:0];
		end else begin
			p_sat = p_n[18:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s10) begin
			pres_s10 <= p_sat;
			temp_s10 <= temp_s9;
		end
	end

	// stage 11: depth product (2P - surface) * K
	logic signed [20:0] m_n;
	logic [16:0]        k_sel;
	logic signed [37:0] dprod_s11;
	logic [18:0]        pres_s11;
	logic signed [15:0] temp_s11;

	assign m_n   = $signed({1'b0, pres_s10, 1'b0}) - psc_pkg::SURFACE_2P;
	assign k_sel = salt ? psc_pkg::K_SALT : psc_pkg::K_FRESH;

	always_ff @(posedge clk) begin
		if (adv_s11) begin
			dprod_s11 <= m_n * $signed({1'b0, k_sel});
			pres_s11  <= pres_s10;
			temp_s11  <= temp_s10;
		end
	end

	// stage 12: floor shift by 17, saturate, output register
	logic signed [37:0] dq;
	logic signed [20:0] d_n;
	logic signed [19:0] d_sat;
	logic signed [19:0] depth_s12;
	logic [18:0]        pres_s12;
	logic signed [15:0] temp_s12;

	assign dq  = dprod_s11 >>> 17;
	assign d_n = dq[20:0];

	always_comb begin
		priority if (d_n < psc_pkg::DEPTH_LO) begin
			d_sat = psc_pkg::DEPTH_LO[19:0];
		end else if (d_n > psc_pkg::DEPTH_HI) begin
			d_sat = psc_pkg::DEPTH_HI[19:0];
		end else begin
			d_sat = d_n[19:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s12) begin
			depth_s12 <= d_sat;
			pres_s12  <= pres_s11;
			temp_s12  <= temp_s11;
		end
	end

	assign res_valid           = vld_s12;
	assign temperature_centi_c = temp_s12;
	assign pressure_tenth_mbar = pres_s12;
	assign depth_mm            = depth_s12;

	// checks
	a_pres_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s12 |-> (pres_s12 <= psc_pkg::PRES_HI[18:0]))
		else $error("pressure beyond saturation limit");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s12 |-> ((depth_s12 >= $signed(psc_pkg::DEPTH_LO[19:0])) &&
			(depth_s12 <= $signed(psc_pkg::DEPTH_HI[19:0]))))
		else $error("depth beyond saturation limit");

	a_last_move: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s11 && adv_s12) |=> vld_s12)
		else $error("transaction lost entering output register");

	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s6 |-> (vld_s6 && vld_s7 && vld_s8 && vld_s9))
		else $error("stage blocked with a bubble ahead");

endmodule
